@@ hdl/vdps_pkg.sv @@
// Shared constants and register indexes for the vertex distance block.
package vdps_pkg;

  localparam int unsigned NumVertices = 64;
  localparam int unsigned IdxW        = 6;
  localparam int unsigned CountW      = 7;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned ScoreW      = 16;
  localparam int unsigned DistW       = 17;
  localparam int unsigned SqW         = 34;
  localparam int unsigned SumW        = 38;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned CoordFrac   = 4;
  localparam int unsigned NumerW      = ScoreW + 16 + CoordFrac;
  localparam int unsigned TermW       = NumerW;

  localparam logic [1:0] ModeLoad   = 2'd0;
  localparam logic [1:0] ModeRow    = 2'd1;
  localparam logic [1:0] ModeScore  = 2'd2;
  localparam logic [1:0] ModeUnused = 2'd3;

  localparam logic [CfgIdxW-1:0] RegPointCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHotelCount = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPoiCount   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegImportance = 2'd3;

  localparam logic [SqW-1:0]  OneSq  = SqW'(1) << (2 * CoordFrac);
  localparam logic [SumW-1:0] SumMax = '1;

endpackage

@@ hdl/vdps_isqrt.sv @@
// Multicycle floor square root, one result bit per cycle.
module vdps_isqrt
  import vdps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SqW-1:0]   radicand_i,
  output logic             done_o,
  output logic [DistW-1:0] root_o
);

  localparam int unsigned Steps = SqW / 2;

  logic [SqW-1:0]   rem_q, rem_d;
  logic [DistW-1:0] root_q, root_d;
  logic [SqW-1:0]   rad_q, rad_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [SqW+1:0]   trial;
  logic [SqW+1:0]   rem_sh;

  always_comb begin
    rem_d  = rem_q;
    root_d = root_q;
    rad_d  = rad_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q, rad_q[SqW-1 -: 2]};
    trial  = {(SqW+2-DistW-2)'(0), root_q, 2'b01};
    if (start_i) begin
      rem_d  = '0;
      root_d = '0;
      rad_d  = radicand_i;
      cnt_d  = 5'(Steps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = rad_q << 2;
      if (rem_sh >= trial) begin
        rem_d  = SqW'(rem_sh - trial);
        root_d = {root_q[DistW-2:0], 1'b1};
      end else begin
        rem_d  = SqW'(rem_sh);
        root_d = {root_q[DistW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    rad_q  <= rad_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ hdl/vdps_div.sv @@
// Multicycle restoring divider, one quotient bit per cycle.
module vdps_div
  import vdps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NumerW-1:0] numer_i,
  input  logic [DistW-1:0]  denom_i,
  output logic              done_o,
  output logic [NumerW-1:0] quot_o
);

  logic [NumerW-1:0] quot_q, quot_d;
  logic [DistW-1:0]  den_q, den_d;
  logic [DistW:0]    rem_q, rem_d;
  logic [DistW+1:0]  rem_sh;
  logic [5:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  always_comb begin
    quot_d = quot_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q, quot_q[NumerW-1]};
    if (start_i) begin
      quot_d = numer_i;
      den_d  = denom_i;
      rem_d  = '0;
      cnt_d  = 6'(NumerW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {2'b00, den_q}) begin
        rem_d  = (DistW+1)'(rem_sh - {2'b00, den_q});
        quot_d = {quot_q[NumerW-2:0], 1'b1};
      end else begin
        rem_d  = (DistW+1)'(rem_sh);
        quot_d = {quot_q[NumerW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ hdl/vertex_distance_and_proximity_score.sv @@
// Vertex store with distance rows and a proximity score over a shared root/divide unit.
//
// Usage: raise start with mode_i and the payload while busy is low; the
// transfer happens at that edge. A load writes one vertex and gives no
// result; busy stays high for one cycle after it. A row request gives
// min(point_count, 64) results, one per column, each shown for one
// cycle with valid_o and last_o on the final one. A score request gives
// one result. A request first takes the addressed vertex (StAnchor).
// Each column then passes an end check and a memory read (StRdA, StRdB),
// the squares and their sum (StSq, StSum) and a 17-step bit-serial square
// root (StRoot). A far point of interest adds a 36-step serial divide
// (StDiv) and its accumulate (StAcc). The receiver cannot stall: results
// are strobed once and must be taken. Configuration writes (cfg_we_i,
// cfg_idx_i, cfg_data_i) take effect at once; the user must make them only
// while busy is low, which the block does not enforce. Reset returns the
// configuration registers to their defaults and the controller to idle;
// the vertex memory keeps its contents and is undefined until loaded.
module vertex_distance_and_proximity_score
  import vdps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode_i,
  input  logic [IdxW-1:0]     vertex_index_i,
  input  logic signed [CoordW-1:0] coord_x_i,
  input  logic signed [CoordW-1:0] coord_y_i,
  input  logic [ScoreW-1:0]   point_score_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                valid_o,
  output logic [IdxW-1:0]     column_index_o,
  output logic [DistW-1:0]    distance_o,
  output logic [SumW-1:0]     score_sum_o,
  output logic                last_o
);

  typedef enum logic [3:0] {
    StIdle, StLoad, StAnchor, StRdA, StRdB, StSq, StSum, StRoot, StDiv, StAcc, StDone
  } state_e;

  localparam int unsigned MemW = 2 * CoordW + ScoreW;

  logic [MemW-1:0] mem_q [NumVertices];
  logic [MemW-1:0] rd_q;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;

  state_e state_q;
  logic [CountW-1:0] pc_q, hc_q, poi_q;
  logic [15:0]       imp_q;
  logic [1:0]        mode_q;
  logic [IdxW-1:0]   idx_q;
  logic [CountW:0]   j_q, end_q;
  logic signed [CoordW-1:0] ax_q, ay_q;
  logic signed [CoordW:0]   dx_q, dy_q;
  logic [ScoreW-1:0] sc_q;
  logic [SqW-2:0]    sqx_q, sqy_q;
  logic [SqW-1:0]    s_q;
  logic [SqW-1:0]    s_next;
  logic [NumerW-1:0] numer_q;
  logic [SumW:0]     sum_q;
  logic [SumW:0]     sum_add;
  logic              valid_q, last_q;
  logic [IdxW-1:0]   col_q;
  logic [DistW-1:0]  dist_q;
  logic [SumW-1:0]   ssum_q;

  logic             sq_start, sq_done, dv_start, dv_done;
  logic [DistW-1:0] root;
  logic [NumerW-1:0] quot;
  logic [31:0]      prod_q;

  assign wr_en   = start && !busy && mode_i == ModeLoad;
  assign rd_addr = (state_q == StIdle) ? vertex_index_i : j_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[vertex_index_i] <= {coord_x_i, coord_y_i, point_score_i};
    end
    rd_q <= mem_q[rd_addr];
  end

  assign s_next   = (j_q[IdxW-1:0] == idx_q) ? '0 : SqW'(sqx_q) + SqW'(sqy_q);
  assign sq_start = state_q == StSum;
  assign dv_start = state_q == StRoot && sq_done && mode_q == ModeScore && s_q > OneSq;

  vdps_isqrt u_isqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .radicand_i(s_next), .done_o(sq_done), .root_o(root)
  );

  vdps_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .numer_i(numer_q), .denom_i(root),
    .done_o(dv_done), .quot_o(quot)
  );

  always_comb begin
    sum_add = sum_q + (SumW+1)'(((state_q == StAcc) ? quot : NumerW'({sc_q, 8'd0})));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pc_q    <= 7'd64;
      hc_q    <= '0;
      poi_q   <= '0;
      imp_q   <= 16'd256;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegPointCount: pc_q  <= cfg_data_i[CountW-1:0];
          RegHotelCount: hc_q  <= cfg_data_i[CountW-1:0];
          RegPoiCount:   poi_q <= cfg_data_i[CountW-1:0];
          RegImportance: imp_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (start) begin
            mode_q <= mode_i;
            idx_q  <= vertex_index_i;
            sum_q  <= '0;
            if (mode_i == ModeLoad) begin
              state_q <= StLoad;
            end else if (mode_i == ModeRow) begin
              j_q   <= '0;
              end_q <= (pc_q > 7'd64) ? 8'd64 : {1'b0, pc_q};
              state_q <= (pc_q == '0) ? StIdle : StAnchor;
            end else if (mode_i == ModeScore) begin
              j_q   <= {1'b0, hc_q};
              end_q <= {1'b0, hc_q} + {1'b0, poi_q};
              state_q <= StAnchor;
            end
          end
        end
        StLoad: state_q <= StIdle;
        StAnchor: begin
          ax_q <= rd_q[MemW-1 -: CoordW];
          ay_q <= rd_q[ScoreW +: CoordW];
          state_q <= StRdA;
        end
        StRdA: begin
          if (j_q >= end_q || j_q >= 8'd64) begin
            state_q <= StDone;
          end else begin
            state_q <= StRdB;
          end
        end
        StRdB: begin
          dx_q <= (CoordW+1)'(ax_q) - (CoordW+1)'($signed(rd_q[MemW-1 -: CoordW]));
          dy_q <= (CoordW+1)'(ay_q) - (CoordW+1)'($signed(rd_q[ScoreW +: CoordW]));
          sc_q <= rd_q[ScoreW-1:0];
          state_q <= StSq;
        end
        StSq: begin
          sqx_q  <= (SqW-1)'(SqW'(dx_q) * SqW'(dx_q));
          sqy_q  <= (SqW-1)'(SqW'(dy_q) * SqW'(dy_q));
          prod_q <= imp_q * sc_q;
          state_q <= StSum;
        end
        StSum: begin
          s_q <= s_next;
          numer_q <= {prod_q, CoordFrac'(0)};
          state_q <= StRoot;
        end
        StRoot: begin
          if (sq_done) begin
            if (mode_q == ModeRow) begin
              valid_q <= 1'b1;
              col_q   <= j_q[IdxW-1:0];
              dist_q  <= root;
              ssum_q  <= '0;
              last_q  <= (j_q + 8'd1) == end_q;
              j_q     <= j_q + 8'd1;
              state_q <= ((j_q + 8'd1) == end_q) ? StIdle : StRdA;
            end else if (s_q > OneSq) begin
              state_q <= StDiv;
            end else begin
              sum_q   <= (sum_add > (SumW+1)'(SumMax)) ? (SumW+1)'(SumMax) : sum_add;
              j_q     <= j_q + 8'd1;
              state_q <= StRdA;
            end
          end
        end
        StDiv: if (dv_done) state_q <= StAcc;
        StAcc: begin
          sum_q   <= (sum_add > (SumW+1)'(SumMax)) ? (SumW+1)'(SumMax) : sum_add;
          j_q     <= j_q + 8'd1;
          state_q <= StRdA;
        end
        StDone: begin
          valid_q <= 1'b1;
          last_q  <= 1'b1;
          col_q   <= '0;
          dist_q  <= '0;
          ssum_q  <= sum_q[SumW-1:0];
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy           = state_q != StIdle;
  assign valid_o        = valid_q;
  assign last_o         = last_q;
  assign column_index_o = col_q;
  assign distance_o     = dist_q;
  assign score_sum_o    = ssum_q;

  a_last_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> valid_o) else $error("last without valid");
  a_busy_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> busy) else $error("row ended early");
  a_load_holds_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i == ModeLoad) |=> busy)
    else $error("load transfer without busy");

endmodule
